// ----- sv/bleadv_pkg.sv -----
// Shared types and constants for the BLE advertising data field extractor.
package bleadv_pkg;

  localparam int MAX_REPORT_BYTES_DEF = 31;

  localparam logic [7:0] AD_TYPE_FLAGS      = 8'h01;
  localparam logic [7:0] AD_TYPE_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_TYPE_NAME_FULL  = 8'h09;
  localparam logic [7:0] AD_TYPE_APPEARANCE = 8'h19;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    FT_NONE,
    FT_FLAGS,
    FT_APPEAR,
    FT_NAME
  } ftype_t;

  typedef struct packed {
    logic [7:0]  flags_value;
    logic        flags_found;
    logic [15:0] appearance_value;
    logic        appearance_found;
    logic        name_found;
  } summary_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } name_wr_t;

endpackage

// ----- sv/ble_adv_data_field_extractor.sv -----
// Top level: BLE advertising data parser with summary and name character output.
// Throughput: one data word per cycle; a report's last word waits while the previous
// report's results drain (one result word per unstalled cycle, name length + 1 words).
// After the last data word is accepted the sequencer loads and the summary word is registered,
// followed by the name characters on consecutive cycles when the output is not stalled.
// Reset clears the walker state, the result sequencer and the output valid.
module ble_adv_data_field_extractor import bleadv_pkg::*; #(
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  report_length,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  flags_value,
  output logic        flags_found,
  output logic [15:0] appearance_value,
  output logic        appearance_found,
  output logic        name_found,
  output logic [4:0]  name_length,
  output logic [7:0]  name_char,
  output logic [4:0]  name_index,
  output logic        last_result
);

  localparam int NAME_DEPTH = MAX_REPORT_BYTES - 2;
  localparam int NAME_CNT_W = $clog2(NAME_DEPTH + 1);
  localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

  logic                  take;
  logic                  busy;
  logic                  job_load;
  summary_t              summary;
  logic [NAME_CNT_W-1:0] job_nlen;
  logic                  wbank;
  name_wr_t              name_wr;
  logic [NAME_AW-1:0]    name_waddr;

  assign in_stall = last_byte && busy;
  assign take     = in_valid && !in_stall;

  bleadv_parser #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .report_length (report_length),
    .last_byte     (last_byte),
    .job_load      (job_load),
    .summary       (summary),
    .job_nlen      (job_nlen),
    .wbank         (wbank),
    .name_wr       (name_wr),
    .name_waddr    (name_waddr)
  );

  bleadv_emit #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_emit (
    .clk              (clk),
    .rst              (rst),
    .job_load         (job_load),
    .summary          (summary),
    .job_nlen         (job_nlen),
    .wbank            (wbank),
    .name_wr          (name_wr),
    .name_waddr       (name_waddr),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .flags_value      (flags_value),
    .flags_found      (flags_found),
    .appearance_value (appearance_value),
    .appearance_found (appearance_found),
    .name_found       (name_found),
    .name_length      (name_length),
    .name_char        (name_char),
    .name_index       (name_index),
    .last_result      (last_result)
  );

endmodule

// ----- sv/bleadv_parser.sv -----
// AD structure walker: tracks length/type/value phases and captures target fields.
module bleadv_parser import bleadv_pkg::*; #(
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF,
  localparam int NAME_DEPTH = MAX_REPORT_BYTES - 2,
  localparam int NAME_CNT_W = $clog2(NAME_DEPTH + 1),
  localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic [4:0]             report_length,
  input  logic                   last_byte,
  output logic                   job_load,
  output summary_t               summary,
  output logic [NAME_CNT_W-1:0]  job_nlen,
  output logic                   wbank,
  output name_wr_t               name_wr,
  output logic [NAME_AW-1:0]     name_waddr
);

  localparam logic [7:0] MAX_B = 8'(MAX_REPORT_BYTES);
  localparam logic [NAME_CNT_W-1:0] NAME_DEPTH_C = NAME_CNT_W'(NAME_DEPTH);
  localparam logic [NAME_CNT_W-1:0] CNT_ONE = NAME_CNT_W'(1);

  phase_t                phase, phase_next;
  ftype_t                ftype, ftype_next;
  logic [7:0]            pos;
  logic [5:0]            nhp, nhp_next;
  logic [7:0]            vbase, vbase_next;
  logic                  stopped, stopped_next;
  logic                  flags_found, flags_found_next;
  logic                  app_found, app_found_next;
  logic                  name_found, name_found_next;
  logic [7:0]            flags_store, flags_store_next;
  logic [15:0]           app_store, app_store_next;
  logic [NAME_CNT_W-1:0] name_count, name_count_next;
  logic                  last_zero, last_zero_next;

  logic [7:0]            size;
  logic                  active;
  logic [9:0]            hdr_end;
  logic                  bad_len;
  logic                  field_end;
  logic [NAME_CNT_W-1:0] nlen_raw;

  assign size      = ({3'b000, report_length} > MAX_B) ? MAX_B : {3'b000, report_length};
  assign active    = !stopped && (pos < size);
  assign hdr_end   = {2'b00, pos} + {2'b00, data_byte} + 10'd1;
  assign bad_len   = (data_byte == 8'd0) || (hdr_end > {2'b00, size});
  assign field_end = (({1'b0, pos} + 9'd1) == {3'b000, nhp});

  always_comb begin
    phase_next = phase;
    if (active) begin
      case (phase)
        PH_LEN:   if (!bad_len) phase_next = PH_TYPE;
        PH_TYPE:  phase_next = field_end ? PH_LEN : PH_VALUE;
        PH_VALUE: if (field_end) phase_next = PH_LEN;
        default:  phase_next = PH_LEN;
      endcase
    end
  end

  always_comb begin
    ftype_next       = ftype;
    nhp_next         = nhp;
    vbase_next       = vbase;
    stopped_next     = stopped;
    flags_found_next = flags_found;
    app_found_next   = app_found;
    name_found_next  = name_found;
    flags_store_next = flags_store;
    app_store_next   = app_store;
    name_count_next  = name_count;
    last_zero_next   = last_zero;
    name_wr.en       = 1'b0;
    name_wr.data     = data_byte;
    if (active) begin
      case (phase)
        PH_LEN: begin
          if (bad_len) stopped_next = 1'b1;
          else begin
            nhp_next   = hdr_end[5:0];
            vbase_next = pos + 8'd2;
          end
        end
        PH_TYPE: begin
          ftype_next = FT_NONE;
          if (data_byte == AD_TYPE_FLAGS && !flags_found) begin
            flags_found_next = 1'b1;
            flags_store_next = 8'd0;
            ftype_next       = FT_FLAGS;
          end else if (data_byte == AD_TYPE_APPEARANCE && !app_found) begin
            app_found_next = 1'b1;
            app_store_next = 16'd0;
            ftype_next     = FT_APPEAR;
          end else if ((data_byte == AD_TYPE_NAME_SHORT || data_byte == AD_TYPE_NAME_FULL) &&
                       !name_found) begin
            name_found_next = 1'b1;
            name_count_next = '0;
            ftype_next      = FT_NAME;
          end
        end
        PH_VALUE: begin
          case (ftype)
            FT_FLAGS: if (pos == vbase) flags_store_next = data_byte;
            FT_APPEAR: begin
              if (pos == vbase) app_store_next[7:0] = data_byte;
              else if (pos == vbase + 8'd1) app_store_next[15:8] = data_byte;
            end
            FT_NAME: begin
              if (name_count < NAME_DEPTH_C) begin
                name_wr.en      = take;
                name_count_next = name_count + CNT_ONE;
                last_zero_next  = (data_byte == 8'd0);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign name_waddr = NAME_AW'(name_count);

  // name length, less one trailing zero
  always_comb begin
    nlen_raw = name_found_next ? name_count_next : '0;
    if (nlen_raw != '0 && last_zero_next) nlen_raw = nlen_raw - CNT_ONE;
  end

  assign job_load                 = take && last_byte;
  assign job_nlen                 = nlen_raw;
  assign summary.flags_value      = flags_store_next;
  assign summary.flags_found      = flags_found_next;
  assign summary.appearance_value = app_store_next;
  assign summary.appearance_found = app_found_next;
  assign summary.name_found       = name_found_next;

  always_ff @(posedge clk) begin
    if (rst || job_load) begin
      phase       <= PH_LEN;
      ftype       <= FT_NONE;
      pos         <= 8'd0;
      nhp         <= 6'd0;
      vbase       <= 8'd0;
      stopped     <= 1'b0;
      flags_found <= 1'b0;
      app_found   <= 1'b0;
      name_found  <= 1'b0;
      flags_store <= 8'd0;
      app_store   <= 16'd0;
      name_count  <= '0;
      last_zero   <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      ftype       <= ftype_next;
      pos         <= (pos == 8'd255) ? pos : pos + 8'd1;
      nhp         <= nhp_next;
      vbase       <= vbase_next;
      stopped     <= stopped_next;
      flags_found <= flags_found_next;
      app_found   <= app_found_next;
      name_found  <= name_found_next;
      flags_store <= flags_store_next;
      app_store   <= app_store_next;
      name_count  <= name_count_next;
      last_zero   <= last_zero_next;
    end
  end

  // name buffer alternates per report
  always_ff @(posedge clk) begin
    if (rst) begin
      wbank <= 1'b0;
    end else if (job_load) begin
      wbank <= !wbank;
    end
  end

  a_name_count_bound: assert property (@(posedge clk) disable iff (rst)
    name_count <= NAME_DEPTH_C)
    else $error("name count past buffer depth");

  a_field_inside_report: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_LEN) |-> ({2'b00, nhp} > pos))
    else $error("field end behind current byte");

endmodule

// ----- sv/bleadv_emit.sv -----
// Result sequencer: double-buffered name store and output register.
module bleadv_emit import bleadv_pkg::*; #(
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF,
  localparam int NAME_DEPTH = MAX_REPORT_BYTES - 2,
  localparam int NAME_CNT_W = $clog2(NAME_DEPTH + 1),
  localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_load,
  input  summary_t              summary,
  input  logic [NAME_CNT_W-1:0] job_nlen,
  input  logic                  wbank,
  input  name_wr_t              name_wr,
  input  logic [NAME_AW-1:0]    name_waddr,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic [7:0]            flags_value,
  output logic                  flags_found,
  output logic [15:0]           appearance_value,
  output logic                  appearance_found,
  output logic                  name_found,
  output logic [4:0]            name_length,
  output logic [7:0]            name_char,
  output logic [4:0]            name_index,
  output logic                  last_result
);

  localparam logic [NAME_CNT_W-1:0] CNT_ONE = NAME_CNT_W'(1);

  logic [7:0] bank0 [NAME_DEPTH];
  logic [7:0] bank1 [NAME_DEPTH];

  logic                  active;
  logic                  rbank;
  logic [NAME_CNT_W-1:0] idx;
  logic [NAME_CNT_W-1:0] nlen;
  summary_t              job;

  logic [NAME_CNT_W-1:0] cidx;
  logic [NAME_AW-1:0]    raddr;
  logic                  out_free;
  logic                  emit;
  logic                  is_last;

  always_ff @(posedge clk) begin
    if (name_wr.en) begin
      if (wbank) bank1[name_waddr] <= name_wr.data;
      else bank0[name_waddr] <= name_wr.data;
    end
  end

  assign cidx     = idx - CNT_ONE;
  assign raddr    = NAME_AW'(cidx);
  assign out_free = !out_valid || !out_stall;
  assign emit     = active && out_free;
  assign is_last  = (idx == nlen);
  assign busy     = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= emit;
      if (job_load) begin
        active <= 1'b1;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      idx   <= '0;
      nlen  <= job_nlen;
      job   <= summary;
      rbank <= wbank;
    end else if (emit) begin
      idx <= idx + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_result <= is_last;
      if (idx == '0) begin
        result_kind      <= 1'b0;
        flags_value      <= job.flags_value;
        flags_found      <= job.flags_found;
        appearance_value <= job.appearance_value;
        appearance_found <= job.appearance_found;
        name_found       <= job.name_found;
        name_length      <= 5'(nlen);
        name_char        <= 8'd0;
        name_index       <= 5'd0;
      end else begin
        result_kind      <= 1'b1;
        flags_value      <= 8'd0;
        flags_found      <= 1'b0;
        appearance_value <= 16'd0;
        appearance_found <= 1'b0;
        name_found       <= 1'b0;
        name_length      <= 5'd0;
        name_char        <= rbank ? bank1[raddr] : bank0[raddr];
        name_index       <= 5'(cidx);
      end
    end
  end

  a_no_job_overlap: assert property (@(posedge clk) disable iff (rst)
    job_load |-> !active)
    else $error("new report summary while previous one still draining");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx <= nlen))
    else $error("result index past name length");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last && !job_load) |=> !active)
    else $error("sequencer still busy after final word");

endmodule
